>>> rtl/core/bpe_pkg.sv
package bpe_pkg;

    localparam int MAX_POINTS = 16;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int COORD_W    = 32;
    localparam int T_W        = 17;
    localparam int FUNC_W     = 2;
    localparam int FRAC_W     = 16;
    localparam int PROD_W     = (COORD_W + 1) + (T_W + 1);
    localparam int IN_FIELD_W = 2 * COORD_W + T_W;
    localparam int IN_TDATA_W = ((IN_FIELD_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 2 * COORD_W;
    localparam logic [T_W-1:0] T_ONE = T_W'(1 << FRAC_W);

    typedef enum logic [FUNC_W-1:0] {
        F_APPEND = 2'd0,
        F_EVAL   = 2'd1,
        F_CLEAR  = 2'd2,
        F_NOP    = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LVL,
        S_P,
        S_MUL,
        S_ACC,
        S_NXT,
        S_OUT
    } t_step;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_ZERO,
        RD_IDX1,
        RD_IDX2
    } t_rdsel;

    typedef enum logic [2:0] {
        C_NONE,
        C_ALWAYS,
        C_LVL_ONE,
        C_MORE,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        logic   idle;
        t_rdsel rd;
        logic   ld_p;
        logic   ld_mul;
        logic   wr_work;
        logic   shift_pq;
        logic   idx_clr;
        logic   idx_inc;
        logic   lvl_dec;
        logic   emit;
        t_cond  cond;
        t_step  jmp;
        t_step  nxt;
    } t_uword;

    function automatic t_uword ucode(input t_step s);
        t_uword w;
        w = '{idle: 1'b0, rd: RD_NONE, ld_p: 1'b0, ld_mul: 1'b0, wr_work: 1'b0,
              shift_pq: 1'b0, idx_clr: 1'b0, idx_inc: 1'b0, lvl_dec: 1'b0,
              emit: 1'b0, cond: C_NONE, jmp: S_IDLE, nxt: S_IDLE};
        unique case (s)
            S_IDLE: begin
                w.idle = 1'b1;
                w.nxt  = S_IDLE;
            end
            S_LVL: begin
                w.rd      = RD_ZERO;
                w.idx_clr = 1'b1;
                w.nxt     = S_P;
            end
            S_P: begin
                w.ld_p = 1'b1;
                w.rd   = RD_IDX1;
                w.cond = C_LVL_ONE;
                w.jmp  = S_OUT;
                w.nxt  = S_MUL;
            end
            S_MUL: begin
                w.ld_mul = 1'b1;
                w.nxt    = S_ACC;
            end
            S_ACC: begin
                w.wr_work  = 1'b1;
                w.shift_pq = 1'b1;
                w.rd       = RD_IDX2;
                w.idx_inc  = 1'b1;
                w.cond     = C_MORE;
                w.jmp      = S_MUL;
                w.nxt      = S_NXT;
            end
            S_NXT: begin
                w.lvl_dec = 1'b1;
                w.cond    = C_ALWAYS;
                w.jmp     = S_LVL;
            end
            S_OUT: begin
                w.emit = 1'b1;
                w.cond = C_OUT_BUSY;
                w.jmp  = S_OUT;
                w.nxt  = S_IDLE;
            end
            default: begin
                w.nxt = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

>>> rtl/core/bezier_point_evaluator.sv
// Bezier point evaluator by de Casteljau reduction over up to MAX_POINTS stored 2-D
// control points (signed Q16.16). tuser selects the operation: append a point, evaluate
// at t (unsigned Q1.16, values above 1.0 saturate), or clear. Append, clear and unused
// codes give no output beat. An evaluate raises one output beat, which with an empty
// store flags empty_error with zero coordinates, and the input is ready again in the
// same cycle that the beat is raised. All lerps share the single interpolator per
// coordinate; each takes a multiply step and an add/write-back step, sequenced by a
// small microprogram over one read port of the point store. One item is worked at a
// time; a finished beat waits in the output register while the next is taken, and an
// evaluate that finishes while that beat still waits holds its own beat, with the input
// stalled, until the waiting one leaves.
module bezier_point_evaluator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [bpe_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // point_x, point_y, t_param
    input  logic [bpe_pkg::FUNC_W-1:0]         s_axis_tuser,  // func
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [bpe_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // curve_x, curve_y
    output logic [0:0]                         m_axis_tuser   // empty_error
);
    import bpe_pkg::*;

    t_step  r_step, n_step;
    t_uword uw;
    t_func  func;

    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_lvl, n_lvl;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic              r_first, n_first;
    logic              r_out_valid, n_out_valid;

    logic [T_W-1:0]     r_t;
    logic [COORD_W-1:0] r_px, r_py, r_qx, r_qy;
    logic [PROD_W-1:0]  r_prod_x, r_prod_y;
    logic               r_err;
    logic [COORD_W-1:0] r_out_x, r_out_y;
    logic               r_out_err;

    logic [COORD_W-1:0] ctrl_x_mem [MAX_POINTS];
    logic [COORD_W-1:0] ctrl_y_mem [MAX_POINTS];
    logic [COORD_W-1:0] work_x_mem [MAX_POINTS];
    logic [COORD_W-1:0] work_y_mem [MAX_POINTS];
    logic [COORD_W-1:0] r_ctrl_rd_x, r_ctrl_rd_y, r_work_rd_x, r_work_rd_y;

    logic                      in_fire;
    logic                      out_busy;
    logic                      cond_true;
    logic                      rd_en;
    logic [ADDR_W-1:0]         rd_addr;
    logic [COORD_W-1:0]        rd_x, rd_y;
    logic [COORD_W-1:0]        in_x, in_y;
    logic [T_W-1:0]            in_t, t_sat;
    logic signed [COORD_W:0]   diff_x, diff_y;
    logic signed [T_W:0]       t_s;
    logic signed [PROD_W-1:0]  prod_x, prod_y;
    logic [COORD_W-1:0]        lerp_x, lerp_y;
    logic [CNT_W-1:0]          idx_plus2;

    assign in_x = s_axis_tdata[COORD_W-1:0];
    assign in_y = s_axis_tdata[2*COORD_W-1:COORD_W];
    assign in_t = s_axis_tdata[2*COORD_W+T_W-1:2*COORD_W];
    assign func = t_func'(s_axis_tuser);

    assign uw            = ucode(r_step);
    assign s_axis_tready = uw.idle;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_busy      = r_out_valid && !m_axis_tready;
    assign t_sat         = (in_t > T_ONE) ? T_ONE : in_t;
    assign idx_plus2     = CNT_W'(r_idx) + CNT_W'(2);

    assign rd_x = r_first ? r_ctrl_rd_x : r_work_rd_x;
    assign rd_y = r_first ? r_ctrl_rd_y : r_work_rd_y;

    assign diff_x = $signed({rd_x[COORD_W-1], rd_x}) - $signed({r_px[COORD_W-1], r_px});
    assign diff_y = $signed({rd_y[COORD_W-1], rd_y}) - $signed({r_py[COORD_W-1], r_py});
    assign t_s    = $signed({1'b0, r_t});
    assign prod_x = diff_x * t_s;
    assign prod_y = diff_y * t_s;
    assign lerp_x = r_px + r_prod_x[FRAC_W +: COORD_W];
    assign lerp_y = r_py + r_prod_y[FRAC_W +: COORD_W];

    always_comb begin
        unique case (uw.cond)
            C_NONE:     cond_true = 1'b0;
            C_ALWAYS:   cond_true = 1'b1;
            C_LVL_ONE:  cond_true = (r_lvl == CNT_W'(1));
            C_MORE:     cond_true = (idx_plus2 < r_lvl);
            C_OUT_BUSY: cond_true = out_busy;
            default:    cond_true = 1'b0;
        endcase
    end

    always_comb begin
        rd_en = 1'b1;
        unique case (uw.rd)
            RD_NONE: begin
                rd_en   = 1'b0;
                rd_addr = '0;
            end
            RD_ZERO: rd_addr = '0;
            RD_IDX1: rd_addr = r_idx + ADDR_W'(1);
            RD_IDX2: rd_addr = r_idx + ADDR_W'(2);
            default: begin
                rd_en   = 1'b0;
                rd_addr = '0;
            end
        endcase
    end

    always_comb begin
        n_step = cond_true ? uw.jmp : uw.nxt;
        if (in_fire && func == F_EVAL) begin
            n_step = (r_count == '0) ? S_OUT : S_LVL;
        end
    end

    always_comb begin
        n_count     = r_count;
        n_lvl       = r_lvl;
        n_idx       = r_idx;
        n_first     = r_first;
        n_out_valid = r_out_valid;
        if (in_fire) begin
            unique case (func)
                F_APPEND: if (r_count < CNT_W'(MAX_POINTS)) n_count = r_count + CNT_W'(1);
                F_CLEAR:  n_count = '0;
                F_EVAL: begin
                    n_lvl   = r_count;
                    n_first = 1'b1;
                end
                default: n_count = r_count;
            endcase
        end
        if (uw.idx_clr) n_idx = '0;
        if (uw.idx_inc) n_idx = r_idx + ADDR_W'(1);
        if (uw.lvl_dec) begin
            n_lvl   = r_lvl - CNT_W'(1);
            n_first = 1'b0;
        end
        if (uw.emit && !out_busy) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= S_IDLE;
            r_count     <= '0;
            r_lvl       <= '0;
            r_idx       <= '0;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_count     <= n_count;
            r_lvl       <= n_lvl;
            r_idx       <= n_idx;
            r_first     <= n_first;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && func == F_APPEND && r_count < CNT_W'(MAX_POINTS)) begin
            ctrl_x_mem[r_count[ADDR_W-1:0]] <= in_x;
            ctrl_y_mem[r_count[ADDR_W-1:0]] <= in_y;
        end
        if (rd_en) begin
            r_ctrl_rd_x <= ctrl_x_mem[rd_addr];
            r_ctrl_rd_y <= ctrl_y_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (uw.wr_work) begin
            work_x_mem[r_idx] <= lerp_x;
            work_y_mem[r_idx] <= lerp_y;
        end
        if (rd_en) begin
            r_work_rd_x <= work_x_mem[rd_addr];
            r_work_rd_y <= work_y_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && func == F_EVAL) begin
            r_t   <= t_sat;
            r_err <= (r_count == '0);
            if (r_count == '0) begin
                r_px <= '0;
                r_py <= '0;
            end
        end
        if (uw.ld_p) begin
            r_px <= rd_x;
            r_py <= rd_y;
        end
        if (uw.ld_mul) begin
            r_qx     <= rd_x;
            r_qy     <= rd_y;
            r_prod_x <= prod_x;
            r_prod_y <= prod_y;
        end
        if (uw.shift_pq) begin
            r_px <= r_qx;
            r_py <= r_qy;
        end
        if (uw.emit && !out_busy) begin
            r_out_x   <= r_px;
            r_out_y   <= r_py;
            r_out_err <= r_err;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_y, r_out_x};
    assign m_axis_tuser  = r_out_err;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("point count above store depth");

    a_acc_in_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step == S_ACC |-> CNT_W'(r_idx) + CNT_W'(1) < r_lvl)
        else $error("interpolation index outside current level");

    a_nxt_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step == S_NXT |-> r_lvl > CNT_W'(1))
        else $error("level reduced below one point");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_step) == S_OUT)
        else $error("output beat raised outside output step");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_err |-> r_out_x == '0 && r_out_y == '0)
        else $error("empty error beat with nonzero coordinates");
`endif

endmodule

>>> dv/tb_bezier_point_evaluator.sv
`timescale 1ns / 100ps

module tb_bezier_point_evaluator;
    import bpe_pkg::*;

    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int DRAIN_CYCLES = 320;
    localparam int ITEM_TARGET  = 1350;
    localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;
    localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
    localparam logic [T_W-1:0]     T_HALF    = T_W'(1 << (FRAC_W - 1));
    localparam logic [T_W-1:0]     T_TOP     = '1;

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               err;
    } t_curve_pt;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // point_x, point_y, t_param
    logic [FUNC_W-1:0]      s_axis_tuser;   // func
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // curve_x, curve_y
    logic [0:0]             m_axis_tuser;   // empty_error

    logic signed [COORD_W-1:0] ctrl_x [MAX_POINTS];
    logic signed [COORD_W-1:0] ctrl_y [MAX_POINTS];
    int unsigned               n_loaded;
    t_curve_pt                 curve_q[$];
    int                        err_count;
    int                        items_sent;
    int                        hold_left;
    int                        stall_left;
    bit                        no_idle;

    bezier_point_evaluator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("tb_bezier_point_evaluator failed");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return COORD_MIN;
                    1: return COORD_MAX;
                    2: return '0;
                    default: return '1;
                endcase
            end
            1, 2: return COORD_W'($urandom_range(0, 1 << 20)) - COORD_W'(1 << 19);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [T_W-1:0] rand_t();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return T_ONE;
            2: return T_W'($urandom_range(32'h1_0001, 32'h1_FFFF));
            default: return T_W'($urandom_range(0, 32'h1_0000));
        endcase
    endfunction

    function automatic longint lerp_q16(longint p, longint q, longint t);
        return p + (((q - p) * t) >>> FRAC_W);
    endfunction

    function automatic t_curve_pt predict_curve(logic [T_W-1:0] t_raw);
        longint    wx [MAX_POINTS];
        longint    wy [MAX_POINTS];
        longint    t;
        t_curve_pt pt;
        int        lvl;
        int        i;
        pt.x   = '0;
        pt.y   = '0;
        pt.err = 1'b1;
        if (n_loaded == 0) begin
            return pt;
        end
        t = (t_raw > T_ONE) ? longint'(T_ONE) : longint'(t_raw);
        for (i = 0; i < n_loaded; i++) begin
            wx[i] = longint'(ctrl_x[i]);
            wy[i] = longint'(ctrl_y[i]);
        end
        for (lvl = n_loaded; lvl > 1; lvl--) begin
            for (i = 0; i + 1 < lvl; i++) begin
                wx[i] = lerp_q16(wx[i], wx[i + 1], t);
                wy[i] = lerp_q16(wy[i], wy[i + 1], t);
            end
        end
        pt.x   = wx[0][COORD_W-1:0];
        pt.y   = wy[0][COORD_W-1:0];
        pt.err = 1'b0;
        return pt;
    endfunction

    task automatic apply_item(input t_func func, input logic [COORD_W-1:0] px,
                              input logic [COORD_W-1:0] py, input logic [T_W-1:0] tp);
        case (func)
            F_APPEND: begin
                if (n_loaded < MAX_POINTS) begin
                    ctrl_x[n_loaded] = px;
                    ctrl_y[n_loaded] = py;
                    n_loaded++;
                end
                items_sent++;
            end
            F_EVAL: begin
                curve_q.insert(curve_q.size(), predict_curve(tp));
                items_sent++;
            end
            F_CLEAR: begin
                n_loaded = 0;
                items_sent++;
            end
            default: begin
                items_sent++;
            end
        endcase
    endtask

    task automatic send_item(input t_func func, input logic [COORD_W-1:0] px,
                             input logic [COORD_W-1:0] py, input logic [T_W-1:0] tp);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'({tp, py, px});
        s_axis_tuser  <= func;
        do @(posedge i_clk); while (!s_axis_tready);
        apply_item(func, px, py, tp);
        @(negedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input logic [COORD_W-1:0] got,
                                   input logic [COORD_W-1:0] want);
        $display("%0t: %s mismatch, got %h want %h", $realtime, what, got, want);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        t_curve_pt want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (curve_q.size() == 0) begin
                report_mismatch("unexpected beat", m_axis_tdata[COORD_W-1:0], '0);
            end else begin
                want = curve_q.pop_front();
                if (m_axis_tdata[COORD_W-1:0] !== want.x) begin
                    report_mismatch("curve_x", m_axis_tdata[COORD_W-1:0], want.x);
                end
                if (m_axis_tdata[2*COORD_W-1:COORD_W] !== want.y) begin
                    report_mismatch("curve_y", m_axis_tdata[2*COORD_W-1:COORD_W], want.y);
                end
                if (m_axis_tuser[0] !== want.err) begin
                    report_mismatch("empty_error", COORD_W'(m_axis_tuser[0]),
                                    COORD_W'(want.err));
                end
            end
        end
    end

    initial begin
        m_axis_tready = 1'b0;
        stall_left    = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    task automatic test_empty_store();
        send_item(F_EVAL, rand_coord(), rand_coord(), T_HALF);
        send_item(F_CLEAR, rand_coord(), rand_coord(), rand_t());
        send_item(F_NOP, rand_coord(), rand_coord(), rand_t());
        send_item(F_EVAL, rand_coord(), rand_coord(), T_TOP);
    endtask

    task automatic test_single_point();
        send_item(F_APPEND, COORD_MIN, COORD_MAX, '0);
        send_item(F_EVAL, '0, '0, '0);
        send_item(F_EVAL, '0, '0, T_TOP);
        send_item(F_EVAL, '0, '0, T_ONE);
    endtask

    task automatic test_full_store();
        int i;
        send_item(F_CLEAR, '0, '0, '0);
        send_item(F_APPEND, COORD_MIN, COORD_MAX, '0);
        send_item(F_APPEND, COORD_MAX, COORD_MIN, '0);
        for (i = 2; i < MAX_POINTS + 1; i++) begin
            send_item(F_APPEND, rand_coord(), rand_coord(), rand_t());
        end
        send_item(F_EVAL, '0, '0, T_HALF);
        send_item(F_EVAL, '0, '0, T_ONE - 1'b1);
    endtask

    task automatic test_output_stall();
        int i;
        send_item(F_CLEAR, '0, '0, '0);
        send_item(F_APPEND, rand_coord(), rand_coord(), '0);
        send_item(F_APPEND, rand_coord(), rand_coord(), '0);
        no_idle   = 1'b1;
        hold_left = 2500;
        for (i = 0; i < 8; i++) begin
            send_item(F_EVAL, '0, '0, rand_t());
        end
        no_idle = 1'b0;
    endtask

    task automatic test_random_curves();
        int r;
        int n;
        int i;
        while (items_sent < ITEM_TARGET) begin
            no_idle = ($urandom_range(0, 7) == 0);
            r = $urandom_range(0, 9);
            if (r < 7) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: n = $urandom_range(0, 4);
                    6, 7, 8: n = $urandom_range(5, 10);
                    default: n = $urandom_range(11, 20);
                endcase
                send_item(F_CLEAR, $urandom(), $urandom(), rand_t());
                for (i = 0; i < n; i++) begin
                    send_item(F_APPEND, rand_coord(), rand_coord(), rand_t());
                end
                n = $urandom_range(1, 4);
                for (i = 0; i < n; i++) begin
                    send_item(F_EVAL, $urandom(), $urandom(), rand_t());
                end
            end else if (r == 7) begin
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++) begin
                    send_item(F_APPEND, rand_coord(), rand_coord(), rand_t());
                end
                send_item(F_EVAL, $urandom(), $urandom(), rand_t());
            end else begin
                n = $urandom_range(1, 6);
                for (i = 0; i < n; i++) begin
                    send_item(t_func'($urandom_range(0, 3)), rand_coord(), rand_coord(),
                              T_W'($urandom()));
                end
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = F_NOP;
        n_loaded      = 0;
        err_count     = 0;
        items_sent    = 0;
        hold_left     = 0;
        no_idle       = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_store();
        test_single_point();
        test_full_store();
        test_output_stall();
        test_random_curves();

        s_axis_tvalid <= 1'b0;
        while (curve_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb_bezier_point_evaluator passed");
        end else begin
            $display("tb_bezier_point_evaluator failed");
        end
        $finish;
    end

endmodule
